// ===== design/frq_pkg.sv =====
`default_nettype none
package frq_pkg;

	localparam int unsigned SLOTS      = 16;
	localparam int unsigned SLOT_BYTES = 256;
	localparam int unsigned SLOT_W     = $clog2(SLOTS);
	localparam int unsigned OFF_W      = $clog2(SLOT_BYTES);
	localparam int unsigned ADDR_W     = SLOT_W + OFF_W;
	localparam int unsigned LEN_W      = 9;
	localparam int unsigned CNT_W      = 5;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 9;

	localparam logic [CNT_W-1:0] SLOT_COUNT_RST = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] SLOT_COUNT_MIN = CNT_W'(3);
	localparam logic [LEN_W-1:0] MAX_LENGTH_RST = LEN_W'(SLOT_BYTES);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'b1;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_DROP  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_FULL      = 3'd2,
		ST_BAD_LEN   = 3'd3,
		ST_COMMITTED = 3'd4
	} status_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic       last_byte;
	} cmd_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [7:0]       read_data;
		logic             read_last;
		logic [LEN_W-1:0] frame_length;
		logic [3:0]       stored_frames;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} ram_rd_t;

endpackage
`default_nettype wire

// ===== design/frq_if.sv =====
`default_nettype none
interface frq_cmd_if;
	logic          valid;
	logic          ready;
	frq_pkg::cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface frq_res_if;
	logic          valid;
	logic          ready;
	frq_pkg::res_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== design/frame_ring_queue.sv =====
`default_nettype none
// ring of frame slots with a length per slot, one beat per command
// a command beat accepted waits in s1 for the byte store read, then moves to the output register that drives res
// throughput: one command per cycle; each beat makes at most one byte store access
// stalls: cmd waits while s1 and the output register both hold a beat and res is not ready
// reset: pointers, counts and handshake state clear; slot_count 16, max_length 256
// byte store and length table have no reset and are read only after being written
module frame_ring_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [frq_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [frq_pkg::CFG_DATA_W-1:0] cfg_wdata,
	frq_cmd_if.sink                            cmd,
	frq_res_if.source                          res
);
	import frq_pkg::*;

	// configuration
	logic [CNT_W-1:0] slot_count_q;
	logic [LEN_W-1:0] max_length_q;

	// queue pointers and write progress
	logic [SLOT_W-1:0] read_slot_q;
	logic [SLOT_W-1:0] write_slot_q;
	logic [LEN_W-1:0]  write_count_q;
	logic              write_overflow_q;
	logic [OFF_W-1:0]  read_offset_q;

	// per-slot frame lengths, written on commit only
	logic [LEN_W-1:0] frame_lengths_q [SLOTS];

	// result waiting for the store read, and the output register
	logic  s1_valid_q;
	logic  s1_use_ram_s1;
	res_t  s1_res_s1;
	res_t  s1_out;
	logic  out_valid_q;
	res_t  out_q;

	logic [7:0] ram_rd_data;
	ram_wr_t    ram_wr;
	ram_rd_t    ram_rd;

	logic accept;
	logic advance_s1;

	// next-state values from the command decode
	logic [SLOT_W-1:0] read_slot_d;
	logic [SLOT_W-1:0] write_slot_d;
	logic [LEN_W-1:0]  write_count_d;
	logic              write_overflow_d;
	logic [OFF_W-1:0]  read_offset_d;
	logic              len_we;
	res_t              res_d;
	logic              use_ram_d;

	// s1 drains into the output register when that is free or being emptied
	assign advance_s1 = s1_valid_q && (!out_valid_q || res.ready);
	assign cmd.ready  = !s1_valid_q || advance_s1;
	assign accept     = cmd.valid && cmd.ready;

	assign res.valid   = out_valid_q;
	assign res.payload = out_q;

	always_comb begin
		logic [CNT_W-1:0] n;
		logic [LEN_W-1:0] lim;
		logic [CNT_W-1:0] ws_next;
		logic [CNT_W-1:0] rs_next;
		logic [CNT_W-1:0] ws_prev;
		logic             empty;
		logic             ovf;
		logic [LEN_W-1:0] wc;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] off_inc;
		logic [CNT_W-1:0] fill;

		// clamp the configuration into its legal range
		if (slot_count_q < SLOT_COUNT_MIN) begin
			n = SLOT_COUNT_MIN;
		end else if (slot_count_q > CNT_W'(SLOTS)) begin
			n = CNT_W'(SLOTS);
		end else begin
			n = slot_count_q;
		end
		if (max_length_q == '0) begin
			lim = LEN_W'(1);
		end else if (max_length_q > LEN_W'(SLOT_BYTES)) begin
			lim = LEN_W'(SLOT_BYTES);
		end else begin
			lim = max_length_q;
		end

		ws_next = (CNT_W'(write_slot_q) + CNT_W'(1) >= n) ? '0
			: CNT_W'(write_slot_q) + CNT_W'(1);
		rs_next = (CNT_W'(read_slot_q) + CNT_W'(1) >= n) ? '0
			: CNT_W'(read_slot_q) + CNT_W'(1);
		ws_prev = (write_slot_q == '0) ? n - CNT_W'(1) : CNT_W'(write_slot_q) - CNT_W'(1);
		empty   = (read_slot_q == write_slot_q);
		len     = frame_lengths_q[read_slot_q];
		off_inc = LEN_W'(read_offset_q) + LEN_W'(1);

		read_slot_d      = read_slot_q;
		write_slot_d     = write_slot_q;
		write_count_d    = write_count_q;
		write_overflow_d = write_overflow_q;
		read_offset_d    = read_offset_q;
		len_we           = 1'b0;
		use_ram_d        = 1'b0;
		res_d            = '0;
		ram_wr.en        = 1'b0;
		ram_wr.addr      = {write_slot_q, write_count_q[OFF_W-1:0]};
		ram_wr.data      = cmd.payload.data_byte;
		ram_rd.en        = 1'b0;
		ram_rd.addr      = {read_slot_q, read_offset_q};
		res_d.status     = ST_OK;
		ovf              = 1'b0;
		wc               = write_count_q;

		case (kind_t'(cmd.payload.kind))
			KIND_WRITE: begin
				// bytes past the length limit are not stored
				ovf = write_overflow_q || (write_count_q >= lim);
				if (!ovf) begin
					ram_wr.en = accept;
					wc        = write_count_q + LEN_W'(1);
				end
				write_count_d    = wc;
				write_overflow_d = ovf;
				if (cmd.payload.last_byte) begin
					if (ovf || wc > lim || wc == '0) begin
						res_d.status = ST_BAD_LEN;
					end else if (ws_next[SLOT_W-1:0] == read_slot_q) begin
						res_d.status = ST_FULL;
					end else begin
						len_we       = 1'b1;
						write_slot_d = ws_next[SLOT_W-1:0];
						res_d.status = ST_COMMITTED;
					end
					write_count_d    = '0;
					write_overflow_d = 1'b0;
				end
			end
			KIND_READ: begin
				if (empty) begin
					res_d.status = ST_EMPTY;
				end else begin
					ram_rd.en          = accept;
					use_ram_d          = 1'b1;
					res_d.frame_length = len;
					if (off_inc >= len) begin
						res_d.read_last = 1'b1;
						read_offset_d   = '0;
						read_slot_d     = rs_next[SLOT_W-1:0];
					end else begin
						read_offset_d = off_inc[OFF_W-1:0];
					end
				end
			end
			KIND_DROP: begin
				// keep only the newest frame, restart it from its first byte
				if (empty) begin
					res_d.status = ST_EMPTY;
				end else begin
					read_slot_d   = ws_prev[SLOT_W-1:0];
					read_offset_d = '0;
				end
			end
			default: begin
				read_slot_d      = '0;
				write_slot_d     = '0;
				write_count_d    = '0;
				write_overflow_d = 1'b0;
				read_offset_d    = '0;
			end
		endcase

		fill = CNT_W'(write_slot_d) + n - CNT_W'(read_slot_d);
		if (write_slot_d >= read_slot_d) begin
			fill = CNT_W'(write_slot_d) - CNT_W'(read_slot_d);
		end
		res_d.stored_frames = fill[3:0];
	end

	frq_ram u_ram (
		.clk     (clk),
		.wr      (ram_wr),
		.rd      (ram_rd),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk) begin
		if (accept && len_we) begin
			frame_lengths_q[write_slot_q] <= write_count_d == '0 ? write_count_q + LEN_W'(1)
				: write_count_q + LEN_W'(1);
		end
	end

	// configuration and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q     <= SLOT_COUNT_RST;
			max_length_q     <= MAX_LENGTH_RST;
			read_slot_q      <= '0;
			write_slot_q     <= '0;
			write_count_q    <= '0;
			write_overflow_q <= 1'b0;
			read_offset_q    <= '0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_SLOT_COUNT: begin
					// a new ring size empties the queue
					slot_count_q     <= cfg_wdata[CNT_W-1:0];
					read_slot_q      <= '0;
					write_slot_q     <= '0;
					write_count_q    <= '0;
					write_overflow_q <= 1'b0;
					read_offset_q    <= '0;
				end
				REG_MAX_LENGTH: begin
					max_length_q <= cfg_wdata[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			read_slot_q      <= read_slot_d;
			write_slot_q     <= write_slot_d;
			write_count_q    <= write_count_d;
			write_overflow_q <= write_overflow_d;
			read_offset_q    <= read_offset_d;
		end
	end

	// result pipe: s1 waits for the byte store read, then the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (advance_s1) begin
				s1_valid_q <= 1'b0;
			end
			if (advance_s1) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// merge the store read data into the waiting result
	always_comb begin
		s1_out = s1_res_s1;
		if (s1_use_ram_s1) begin
			s1_out.read_data = ram_rd_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_res_s1     <= res_d;
			s1_use_ram_s1 <= use_ram_d;
		end
		if (advance_s1) begin
			out_q <= s1_out;
		end
	end

endmodule
`default_nettype wire

// ===== design/frq_ram.sv =====
`default_nettype none
module frq_ram (
	input  wire logic            clk,
	input  wire frq_pkg::ram_wr_t wr,
	input  wire frq_pkg::ram_rd_t rd,
	output logic [7:0]           rd_data
);
	import frq_pkg::*;

	logic [7:0] mem [SLOTS*SLOT_BYTES];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/frame_ring_queue_tb.sv =====
`default_nettype none
module frame_ring_queue_tb;
	import frq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD   = 80;   // receiver back-pressure stretch
	localparam int unsigned DRAIN_TAIL  = 8;    // margin past the s1 and output registers

	// ------------------------------------------------------------------
	// frame ring predictor and store of expected results
	// ------------------------------------------------------------------
	class ring_tracker;
		logic [7:0]        slot_bytes [SLOTS*SLOT_BYTES];
		logic [LEN_W-1:0]  slot_lengths [SLOTS];
		logic [CNT_W-1:0]  slot_count;
		logic [LEN_W-1:0]  max_length;
		logic [SLOT_W-1:0] rd_slot;
		logic [SLOT_W-1:0] wr_slot;
		logic [LEN_W-1:0]  wr_count;
		bit                wr_overflow;
		logic [OFF_W-1:0]  rd_offset;
		res_t              expected_q[$];
		int unsigned       errors;

		function new();
			slot_count = SLOT_COUNT_RST;
			max_length = MAX_LENGTH_RST;
			errors     = 0;
			empty_ring();
		endfunction

		function void empty_ring();
			rd_slot     = '0;
			wr_slot     = '0;
			rd_offset   = '0;
			wr_count    = '0;
			wr_overflow = 1'b0;
		endfunction

		function int unsigned ring_size();
			int unsigned n;
			n = slot_count;
			if (n < 3) n = 3;
			if (n > SLOTS) n = SLOTS;
			return n;
		endfunction

		function int unsigned length_limit();
			int unsigned m;
			m = max_length;
			if (m < 1) m = 1;
			if (m > SLOT_BYTES) m = SLOT_BYTES;
			return m;
		endfunction

		function int unsigned next_slot(int unsigned s, int unsigned n);
			return (s + 1 >= n) ? 0 : s + 1;
		endfunction

		// bytes still to read from the oldest frame, zero when the ring is empty
		function int unsigned head_bytes_left();
			if (rd_slot == wr_slot) return 0;
			return slot_lengths[rd_slot] - rd_offset;
		endfunction

		function int unsigned outstanding();
			return expected_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_SLOT_COUNT) begin
				slot_count = value[CNT_W-1:0];
				empty_ring();
			end else if (idx == REG_MAX_LENGTH) begin
				max_length = value[LEN_W-1:0];
			end
		endfunction

		function void note_cmd(cmd_t c);
			res_t        exp;
			int unsigned n;
			int unsigned lim;
			int unsigned len;
			n   = ring_size();
			lim = length_limit();
			exp = '0;
			if (rd_slot >= n || wr_slot >= n) empty_ring();
			case (c.kind)
				KIND_WRITE: begin
					if (wr_overflow || wr_count >= lim) begin
						wr_overflow = 1'b1;
					end else begin
						slot_bytes[{wr_slot, wr_count[OFF_W-1:0]}] = c.data_byte;
						wr_count++;
					end
					if (c.last_byte) begin
						if (wr_overflow || wr_count > lim || wr_count == 0) begin
							exp.status = ST_BAD_LEN;
						end else if (next_slot(wr_slot, n) == rd_slot) begin
							exp.status = ST_FULL;
						end else begin
							slot_lengths[wr_slot] = wr_count;
							wr_slot = SLOT_W'(next_slot(wr_slot, n));
							exp.status = ST_COMMITTED;
						end
						wr_count    = '0;
						wr_overflow = 1'b0;
					end
				end
				KIND_READ: begin
					if (rd_slot == wr_slot) begin
						exp.status = ST_EMPTY;
					end else begin
						len = slot_lengths[rd_slot];
						exp.read_data    = slot_bytes[{rd_slot, rd_offset}];
						exp.frame_length = LEN_W'(len);
						if (rd_offset + 1 >= len) begin
							exp.read_last = 1'b1;
							rd_offset = '0;
							rd_slot   = SLOT_W'(next_slot(rd_slot, n));
						end else begin
							rd_offset++;
						end
					end
				end
				KIND_DROP: begin
					// keep only the newest frame, restart it from its first byte
					if (rd_slot == wr_slot) begin
						exp.status = ST_EMPTY;
					end else begin
						rd_slot   = (wr_slot == 0) ? SLOT_W'(n - 1) : wr_slot - 1'b1;
						rd_offset = '0;
					end
				end
				default: empty_ring();
			endcase
			exp.stored_frames = 4'((wr_slot + n - rd_slot) % n);
			expected_q.push_back(exp);
		endfunction

		function void compare_field(string field, int unsigned exp_v, logic [15:0] got_v);
			if (got_v !== 16'(exp_v)) begin
				$error("%s: expected %0d, got %0d", field, exp_v, got_v);
				errors++;
			end
		endfunction

		function void check_res(res_t got);
			res_t exp;
			if (expected_q.size() == 0) begin
				$error("result beat with nothing expected: status %0d", got.status);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			compare_field("status", exp.status, 16'(got.status));
			compare_field("read_data", exp.read_data, 16'(got.read_data));
			compare_field("read_last", exp.read_last, 16'(got.read_last));
			compare_field("frame_length", exp.frame_length, 16'(got.frame_length));
			compare_field("stored_frames", exp.stored_frames, 16'(got.stored_frames));
		endfunction
	endclass

	// ------------------------------------------------------------------
	// signals and block under test
	// ------------------------------------------------------------------
	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	frq_cmd_if cmd ();
	frq_res_if res ();

	frame_ring_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.res       (res)
	);

	ring_tracker tracker = new();

	int unsigned cycle_count;
	int unsigned burst_left;   // beats left in the current sender burst
	int unsigned sent_items;
	bit          hold_req;     // asks the receiver for one long stall

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// every accepted result beat goes against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) tracker.check_res(res.payload);
	end

	// receiver: ready pattern changes after random stretches, with one long
	// hold on request so that the block backs up and stalls its input
	initial begin : receiver
		int unsigned mode;
		int unsigned mode_left;
		int unsigned hold_left;
		logic [7:0]  pat;
		logic [2:0]  pos;
		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		pat       = '1;
		pos       = '0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 96);
				pat       = 8'($urandom);
			end
			mode_left--;
			pos++;
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else begin
				case (mode)
					0:       res.ready <= 1'b1;
					1:       res.ready <= 1'($urandom_range(0, 1));
					2:       res.ready <= pat[pos];
					default: res.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// one command beat; the sender works in bursts with random gaps between
	task automatic send_cmd(input kind_t kind, input logic [7:0] data, input logic last);
		cmd_t        beat;
		int unsigned gap;
		beat.kind      = kind;
		beat.data_byte = data;
		beat.last_byte = last;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				@(negedge clk);
				cmd.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		cmd.valid   <= 1'b1;
		cmd.payload <= beat;
		do @(posedge clk); while (!cmd.ready);
		tracker.note_cmd(beat);
		burst_left--;
		sent_items++;
	endtask

	// write len payload bytes, marking the last one only when close is set
	task automatic send_frame(input int unsigned len, input bit close);
		for (int unsigned i = 0; i < len; i++)
			send_cmd(KIND_WRITE, 8'($urandom), close && (i == len - 1));
	endtask

	task automatic read_bytes(input int unsigned count);
		repeat (count) send_cmd(KIND_READ, 8'($urandom), 1'($urandom));
	endtask

	// stop offering and wait until every expected result beat has arrived
	task automatic settle();
		@(negedge clk);
		cmd.valid <= 1'b0;
		burst_left = 0;
		while (tracker.outstanding() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_wen   <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wen <= 1'b0;
		tracker.write_reg(idx, value);
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] count, input logic [CFG_DATA_W-1:0] maxlen);
		settle();
		cfg_write(REG_SLOT_COUNT, count);
		cfg_write(REG_MAX_LENGTH, maxlen);
	endtask

	// mostly whole frames written and read back, with some partial reads,
	// unfinished frames, drops, clears and fully random beats
	task automatic random_phase(input int unsigned target);
		int unsigned start;
		int unsigned pick;
		int unsigned lim;
		int unsigned len;
		int unsigned left;
		start = sent_items;
		while (sent_items - start < target) begin
			pick = $urandom_range(0, 99);
			lim  = tracker.length_limit();
			if (pick < 52) begin
				len = $urandom_range(0, 99);
				// short frames mostly; full length and overlong only now and then
				if (len < 75)
					len = $urandom_range(1, (lim < 6) ? lim : 6);
				else if (len < ((lim > 40) ? 96 : 88))
					len = $urandom_range(1, (lim < 40) ? lim : 40);
				else if (len < ((lim > 40) ? 98 : 94))
					len = lim + $urandom_range(1, 3);
				else
					len = lim;
				send_frame(len, $urandom_range(0, 9) != 0);
			end else if (pick < 84) begin
				left = tracker.head_bytes_left();
				if (left == 0)
					left = 1;   // empty ring answers empty
				else if ($urandom_range(0, 3) == 0)
					left = $urandom_range(1, left);
				read_bytes(left);
			end else if (pick < 89) begin
				send_cmd(KIND_DROP, 8'($urandom), 1'($urandom));
			end else if (pick < 92) begin
				send_cmd(KIND_CLEAR, 8'($urandom), 1'($urandom));
			end else begin
				send_cmd(kind_t'(2'($urandom)), 8'($urandom), 1'($urandom));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		arst_n      = 1'b0;
		cfg_wen     = 1'b0;
		cfg_idx     = '0;
		cfg_wdata   = '0;
		cmd.valid   = 1'b0;
		cmd.payload = '0;
		cycle_count = 0;
		burst_left  = 0;
		sent_items  = 0;
		hold_req    = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings: empty ring, drop keeps newest, clear drops a partial frame
		send_cmd(KIND_READ, 8'h00, 1'b0);
		send_cmd(KIND_DROP, 8'hff, 1'b1);
		send_cmd(KIND_WRITE, 8'h00, 1'b1);
		send_cmd(KIND_WRITE, 8'hff, 1'b0);
		send_cmd(KIND_WRITE, 8'h80, 1'b1);
		send_cmd(KIND_DROP, 8'h00, 1'b0);
		send_cmd(KIND_READ, 8'h00, 1'b0);
		send_cmd(KIND_READ, 8'h00, 1'b0);
		send_cmd(KIND_WRITE, 8'h12, 1'b0);
		send_cmd(KIND_CLEAR, 8'h00, 1'b0);
		send_cmd(KIND_READ, 8'h00, 1'b0);

		// smallest ring and two-byte frames: full ring, length fault beats full
		set_regs(9'd3, 9'd2);
		send_cmd(KIND_WRITE, 8'h01, 1'b1);
		send_cmd(KIND_WRITE, 8'h02, 1'b1);
		send_cmd(KIND_WRITE, 8'h03, 1'b1);
		send_cmd(KIND_WRITE, 8'h04, 1'b0);
		send_cmd(KIND_WRITE, 8'h05, 1'b0);
		send_cmd(KIND_WRITE, 8'h06, 1'b1);
		send_cmd(KIND_READ, 8'h00, 1'b0);
		send_cmd(KIND_DROP, 8'h00, 1'b0);
		send_cmd(KIND_READ, 8'h00, 1'b0);
		send_cmd(KIND_READ, 8'h00, 1'b0);

		// both registers below range, saturating to three slots and one byte
		set_regs(9'd0, 9'd0);
		random_phase(150);

		// both registers above range; long receiver hold while beats keep coming
		set_regs(9'd511, 9'd511);
		hold_req = 1'b1;
		random_phase(250);
		send_frame(20, 1'b0);

		// max_length lowered under an unfinished 20-byte frame
		settle();
		cfg_write(REG_MAX_LENGTH, 9'd8);
		random_phase(200);

		set_regs(9'd2, 9'd300);
		random_phase(150);
		set_regs(9'd5, 9'd16);
		random_phase(250);
		set_regs(9'd16, 9'd1);
		random_phase(200);
		set_regs(9'd17, 9'd3);
		random_phase(200);
		set_regs(9'd7, 9'd256);
		random_phase(200);

		// drain, then give stray beats a chance to show up
		settle();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (tracker.outstanding() != 0) begin
			$error("%0d expected result beats never arrived", tracker.outstanding());
			tracker.errors++;
		end
		if (tracker.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== files.f =====
design/frq_pkg.sv
design/frq_if.sv
design/frq_ram.sv
design/frame_ring_queue.sv
tb/sv/frame_ring_queue_tb.sv
